// ===== hdl/rre_pkg.sv =====
package rre_pkg;

  localparam int unsigned NSQ  = 32;  // square-root cells, one result bit each
  localparam int unsigned NDV  = 31;  // divider cells, one quotient bit each
  localparam int unsigned NTRM = 10;  // series cells, one Taylor term each

  localparam logic [60:0] HALF_PI_Q56 = 61'h01921FB54442D184;
  localparam int unsigned NQ = 15;    // quadrant compares

  typedef struct packed {
    logic [2:0][31:0] w;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
    logic [3:0] q;
    logic [31:0] x;
  } dv_side_t;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic             zero;
    logic [3:0]       q;
  } sr_side_t;

endpackage

// ===== hdl/rodrigues_rotation_exp_core.sv =====
// channel | dir | tdata fields (lowest bit up)                 | extra
// in_     | in  | omega_x, omega_y, omega_z (3 x 32, Q4.28)     | tvalid/tready
// out_    | out | r00 r01 r02 r10 r11 r12 r20 r21 r22 (Q1.30)   | tvalid/tready
//
// One request per cycle while no held result stalls the row. The datapath is built from
// the 32-cell square-root row, 31-cell divider row and 10 four-stage series cells.
// Reset clears the valid bits only. A held result stalls the whole row only when a
// further result is ready behind it; bubbles are squeezed out meanwhile.
module rodrigues_rotation_exp_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // omega_x, omega_y, omega_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata   // r00, r01, r02, r10, r11, r12, r20, r21, r22
);
  import rre_pkg::*;

  function automatic logic signed [71:0] rshr(input logic signed [71:0] v,
                                              input int unsigned n);
    logic signed [71:0] h;
    h = 72'sd1 <<< (n - 1);
    // ties away from zero: negative values round with one less
    return (v + h - (v[71] ? 72'sd1 : 72'sd0)) >>> n;
  endfunction

  function automatic logic [31:0] entry(input logic signed [71:0] acc);
    logic signed [71:0] v;
    v = rshr(acc, 30);
    if (v > 72'sd1073741824) begin
      return 32'h4000_0000;
    end else if (v < -72'sd1073741824) begin
      return 32'hC000_0000;
    end
    return v[31:0];
  endfunction

  logic adv;
  logic [7:0] v_r;

  // ---- input, squares, sum
  logic signed [31:0] w0_r [3];
  logic signed [31:0] w1_r [3];
  logic [63:0]        sq1_r [3];
  logic [2:0][31:0]   w2_r;
  logic [63:0]        sum2_r;

  assign adv       = !(out_tvalid && !out_tready && v_r[7]);
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        w0_r[i]  <= in_tdata[32*i +: 32];
        w1_r[i]  <= w0_r[i];
        sq1_r[i] <= 64'(w0_r[i]) * 64'(w0_r[i]);
        w2_r[i]  <= w1_r[i];
      end
      sum2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    end
  end

  // ---- square root row
  logic [63:0] sq_rad  [NSQ+1];
  logic [34:0] sq_rem  [NSQ+1];
  logic [31:0] sq_root [NSQ+1];
  logic        sq_vld  [NSQ+1];
  sq_side_t    sq_side [NSQ+1];

  assign sq_rad[0]    = sum2_r;
  assign sq_rem[0]    = '0;
  assign sq_root[0]   = '0;
  assign sq_vld[0]    = v_r[2];
  assign sq_side[0].w = w2_r;

  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    rre_sqrt_cell u_cell (
      .clk, .rst_n, .en(adv),
      .vld_i(sq_vld[g]), .rad_i(sq_rad[g]), .rem_i(sq_rem[g]),
      .root_i(sq_root[g]), .side_i(sq_side[g]),
      .vld_o(sq_vld[g+1]), .rad_o(sq_rad[g+1]), .rem_o(sq_rem[g+1]),
      .root_o(sq_root[g+1]), .side_o(sq_side[g+1])
    );
  end

  // ---- divider set-up and quadrant reduction
  logic [31:0]      theta;
  logic [59:0]      ang;
  logic [3:0]       q_nxt;
  logic [2:0][61:0] num_nxt;
  logic [2:0]       sgn_nxt;
  logic [31:0]      wabs;

  assign theta = sq_root[NSQ];
  assign ang   = {theta, 28'd0};

  always_comb begin
    q_nxt = '0;
    for (int k = 1; k <= NQ; k++) begin
      q_nxt = q_nxt + {3'd0, ({1'b0, ang} >= 61'(61'(k) * HALF_PI_Q56))};
    end
    wabs = '0;
    for (int i = 0; i < 3; i++) begin
      sgn_nxt[i] = sq_side[NSQ].w[i][31];
      wabs       = sgn_nxt[i] ? (~sq_side[NSQ].w[i] + 32'd1) : sq_side[NSQ].w[i];
      num_nxt[i] = {wabs, 30'd0} + 62'(theta[31:1]);
    end
  end

  logic [31:0]      theta3_r, theta4_r;
  logic [2:0][61:0] num3_r, num4_r;
  logic [2:0]       sgn3_r, sgn4_r;
  logic             zero3_r, zero4_r;
  logic [59:0]      ang3_r;
  logic [3:0]       q3_r, q4_r;
  logic [31:0]      x4_r;
  logic [60:0]      rq;

  assign rq = {1'b0, ang3_r} - 61'(61'(q3_r) * HALF_PI_Q56);

  always_ff @(posedge clk) begin
    if (adv) begin
      theta3_r <= theta;
      num3_r   <= num_nxt;
      sgn3_r   <= sgn_nxt;
      zero3_r  <= (theta == '0);
      ang3_r   <= ang;
      q3_r     <= q_nxt;
      theta4_r <= theta3_r;
      num4_r   <= num3_r;
      sgn4_r   <= sgn3_r;
      zero4_r  <= zero3_r;
      q4_r     <= q3_r;
      x4_r     <= 32'((rq + 61'h100_0000) >> 25);
    end
  end

  // ---- divider row
  logic [31:0]      dv_theta [NDV+1];
  logic [2:0][31:0] dv_rem   [NDV+1];
  logic [2:0][30:0] dv_num   [NDV+1];
  logic [2:0][30:0] dv_quo   [NDV+1];
  logic             dv_vld   [NDV+1];
  dv_side_t         dv_side  [NDV+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = {1'b0, num4_r[i][61:31]};
      dv_num[0][i] = num4_r[i][30:0];
    end
  end
  assign dv_theta[0]     = theta4_r;
  assign dv_quo[0]       = '0;
  assign dv_vld[0]       = v_r[4];
  assign dv_side[0].sgn  = sgn4_r;
  assign dv_side[0].zero = zero4_r;
  assign dv_side[0].q    = q4_r;
  assign dv_side[0].x    = x4_r;

  for (genvar g = 0; g < NDV; g++) begin : g_dv
    rre_div_cell u_cell (
      .clk, .rst_n, .en(adv),
      .vld_i(dv_vld[g]), .theta_i(dv_theta[g]), .rem_i(dv_rem[g]),
      .num_i(dv_num[g]), .quo_i(dv_quo[g]), .side_i(dv_side[g]),
      .vld_o(dv_vld[g+1]), .theta_o(dv_theta[g+1]), .rem_o(dv_rem[g+1]),
      .num_o(dv_num[g+1]), .quo_o(dv_quo[g+1]), .side_o(dv_side[g+1])
    );
  end

  // ---- series row
  logic [31:0]      tr_x    [NTRM+1];
  logic [1:0][31:0] tr_t    [NTRM+1];
  logic [1:0][35:0] tr_acc  [NTRM+1];
  logic             tr_vld  [NTRM+1];
  sr_side_t         tr_side [NTRM+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tr_side[0].a[i] = dv_side[NDV].sgn[i] ? (32'd0 - {1'b0, dv_quo[NDV][i]})
                                            : {1'b0, dv_quo[NDV][i]};
    end
  end
  assign tr_side[0].zero = dv_side[NDV].zero;
  assign tr_side[0].q    = dv_side[NDV].q;
  assign tr_x[0]         = dv_side[NDV].x;
  assign tr_t[0][0]      = dv_side[NDV].x;
  assign tr_t[0][1]      = 32'h8000_0000;
  assign tr_acc[0][0]    = {4'd0, dv_side[NDV].x};
  assign tr_acc[0][1]    = 36'h0_8000_0000;
  assign tr_vld[0]       = dv_vld[NDV];

  for (genvar g = 0; g < NTRM; g++) begin : g_tr
    localparam int unsigned DS = (2 * g + 2) * (2 * g + 3);
    localparam int unsigned DC = (2 * g + 1) * (2 * g + 2);
    localparam logic [33:0] MS = 34'((64'd1 << 34) / DS);
    localparam logic [33:0] MC = 34'((64'd1 << 34) / DC);
    localparam logic        SUB = ((g % 2) == 0);

    rre_term_cell u_cell (
      .clk, .rst_n, .en(adv),
      .vld_i(tr_vld[g]), .x_i(tr_x[g]), .t_i(tr_t[g]), .acc_i(tr_acc[g]),
      .dv_i({9'(DC), 9'(DS)}), .mr_i({MC, MS}), .sub_i(SUB), .side_i(tr_side[g]),
      .vld_o(tr_vld[g+1]), .x_o(tr_x[g+1]), .t_o(tr_t[g+1]), .acc_o(tr_acc[g+1]),
      .side_o(tr_side[g+1])
    );
  end

  // ---- matrix assembly
  logic signed [35:0] sn, cs;
  logic signed [35:0] s6_r, c6_r;
  logic signed [31:0] a6_r [3];
  logic signed [63:0] aa6_r [6];
  logic               zero6_r, zero7_r, zero8_r;

  assign sn = tr_acc[NTRM][0];
  assign cs = tr_acc[NTRM][1];

  logic signed [31:0] a_t [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_t[i] = tr_side[NTRM].a[i];
    end
  end

  logic signed [33:0] s7_r;
  logic signed [34:0] omc7_r;
  logic signed [33:0] kk7_r [6];
  logic signed [31:0] a7_r [3];
  logic signed [71:0] ct;

  assign ct = rshr(72'(c6_r), 1);

  logic signed [65:0] sa8_r [3];
  logic signed [68:0] ok8_r [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (tr_side[NTRM].q[1:0])
        2'd0: begin s6_r <= sn;  c6_r <= cs;  end
        2'd1: begin s6_r <= cs;  c6_r <= -sn; end
        2'd2: begin s6_r <= -sn; c6_r <= -cs; end
        2'd3: begin s6_r <= -cs; c6_r <= sn;  end
        default: begin s6_r <= sn; c6_r <= cs; end
      endcase
      for (int i = 0; i < 3; i++) begin
        a6_r[i] <= a_t[i];
        aa6_r[i] <= 64'(a_t[i]) * 64'(a_t[i]);
      end
      aa6_r[3] <= 64'(a_t[0]) * 64'(a_t[1]);
      aa6_r[4] <= 64'(a_t[0]) * 64'(a_t[2]);
      aa6_r[5] <= 64'(a_t[1]) * 64'(a_t[2]);
      zero6_r  <= tr_side[NTRM].zero;

      s7_r    <= 34'(rshr(72'(s6_r), 1));
      omc7_r  <= 35'((72'sd1 <<< 30) - ct);
      kk7_r[0] <= 34'(rshr(-(72'(aa6_r[1]) + 72'(aa6_r[2])), 30));
      kk7_r[1] <= 34'(rshr(-(72'(aa6_r[0]) + 72'(aa6_r[2])), 30));
      kk7_r[2] <= 34'(rshr(-(72'(aa6_r[0]) + 72'(aa6_r[1])), 30));
      kk7_r[3] <= 34'(rshr(72'(aa6_r[3]), 30));
      kk7_r[4] <= 34'(rshr(72'(aa6_r[4]), 30));
      kk7_r[5] <= 34'(rshr(72'(aa6_r[5]), 30));
      a7_r     <= a6_r;
      zero7_r  <= zero6_r;

      for (int i = 0; i < 3; i++) begin
        sa8_r[i] <= 66'(s7_r) * 66'(a7_r[i]);
      end
      for (int i = 0; i < 6; i++) begin
        ok8_r[i] <= 69'(omc7_r) * 69'(kk7_r[i]);
      end
      zero8_r <= zero7_r;
    end
  end

  // ---- output register
  logic signed [71:0] one60;
  logic [8:0][31:0]   res;

  assign one60 = 72'sd1 <<< 60;

  always_comb begin
    res[0] = entry(one60 + 72'(ok8_r[0]));
    res[4] = entry(one60 + 72'(ok8_r[1]));
    res[8] = entry(one60 + 72'(ok8_r[2]));
    res[1] = entry(72'(ok8_r[3]) - 72'(sa8_r[2]));
    res[3] = entry(72'(ok8_r[3]) + 72'(sa8_r[2]));
    res[2] = entry(72'(ok8_r[4]) + 72'(sa8_r[1]));
    res[6] = entry(72'(ok8_r[4]) - 72'(sa8_r[1]));
    res[5] = entry(72'(ok8_r[5]) - 72'(sa8_r[0]));
    res[7] = entry(72'(ok8_r[5]) + 72'(sa8_r[0]));
    if (zero8_r) begin
      res = '0;
      res[0] = 32'h4000_0000;
      res[4] = 32'h4000_0000;
      res[8] = 32'h4000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        v_r[0] <= in_tvalid;
        v_r[1] <= v_r[0];
        v_r[2] <= v_r[1];
        v_r[3] <= sq_vld[NSQ];
        v_r[4] <= v_r[3];
        v_r[5] <= tr_vld[NTRM];
        v_r[6] <= v_r[5];
        v_r[7] <= v_r[6];
      end
      if (!(out_tvalid && !out_tready)) begin
        out_tvalid <= v_r[7];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!(out_tvalid && !out_tready) && v_r[7]) begin
      out_tdata <= res;
    end
  end

endmodule

// ===== hdl/rre_sqrt_cell.sv =====
module rre_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [63:0]       rad_i,
  input  logic [34:0]       rem_i,
  input  logic [31:0]       root_i,
  input  rre_pkg::sq_side_t side_i,
  output logic              vld_o,
  output logic [63:0]       rad_o,
  output logic [34:0]       rem_o,
  output logic [31:0]       root_o,
  output rre_pkg::sq_side_t side_o
);
  import rre_pkg::*;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        take;
  logic [34:0] rem_nxt;
  logic [31:0] root_nxt;

  // one result bit: bring down two radicand bits, try (root*4 + 1)
  always_comb begin
    rem_sh   = {rem_i[32:0], rad_i[63:62]};
    trial    = {1'b0, root_i, 2'b01};
    take     = (rem_sh >= trial);
    rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[61:0], 2'b00};
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      side_o <= side_i;
    end
  end

endmodule

// ===== hdl/rre_div_cell.sv =====
module rre_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [31:0]       theta_i,
  input  logic [2:0][31:0]  rem_i,
  input  logic [2:0][30:0]  num_i,
  input  logic [2:0][30:0]  quo_i,
  input  rre_pkg::dv_side_t side_i,
  output logic              vld_o,
  output logic [31:0]       theta_o,
  output logic [2:0][31:0]  rem_o,
  output logic [2:0][30:0]  num_o,
  output logic [2:0][30:0]  quo_o,
  output rre_pkg::dv_side_t side_o
);
  import rre_pkg::*;

  logic [2:0][32:0] part;
  logic [2:0]       take;
  logic [2:0][31:0] rem_nxt;
  logic [2:0][30:0] quo_nxt;
  logic [2:0][30:0] num_nxt;

  // restoring step on three lanes sharing one divisor
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      part[l]    = {rem_i[l], num_i[l][30]};
      take[l]    = (part[l] >= {1'b0, theta_i});
      rem_nxt[l] = take[l] ? 32'(part[l] - {1'b0, theta_i}) : part[l][31:0];
      quo_nxt[l] = {quo_i[l][29:0], take[l]};
      num_nxt[l] = {num_i[l][29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_o <= theta_i;
      rem_o   <= rem_nxt;
      num_o   <= num_nxt;
      quo_o   <= quo_nxt;
      side_o  <= side_i;
    end
  end

endmodule

// ===== hdl/rre_term_cell.sv =====
module rre_term_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [31:0]       x_i,
  input  logic [1:0][31:0]  t_i,
  input  logic [1:0][35:0]  acc_i,
  input  logic [1:0][8:0]   dv_i,
  input  logic [1:0][33:0]  mr_i,
  input  logic              sub_i,
  input  rre_pkg::sr_side_t side_i,
  output logic              vld_o,
  output logic [31:0]       x_o,
  output logic [1:0][31:0]  t_o,
  output logic [1:0][35:0]  acc_o,
  output rre_pkg::sr_side_t side_o
);
  import rre_pkg::*;

  // lane 0 sine, lane 1 cosine; four stages per term
  logic [2:0]        vld_r;
  logic [2:0][31:0]  x_r;
  logic [2:0][1:0][35:0] acc_r;
  sr_side_t          side_r [3];

  logic [1:0][63:0]  p1_r;
  logic [1:0][64:0]  p2_r;
  logic [1:0][67:0]  pr_r;
  logic [1:0][33:0]  n_r;

  logic [1:0][63:0]  p1_nxt;
  logic [1:0][32:0]  m1;
  logic [1:0][64:0]  p2_nxt;
  logic [1:0][33:0]  t2;
  logic [1:0][33:0]  n_nxt;
  logic [1:0][67:0]  pr_nxt;
  logic [1:0][33:0]  q0;
  logic [1:0][33:0]  rem;
  logic [1:0][33:0]  tq;
  logic [1:0][35:0]  acc_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p1_nxt[l] = 64'(t_i[l]) * 64'(x_i);
      m1[l]     = 33'((p1_r[l] + 64'h4000_0000) >> 31);
      p2_nxt[l] = 65'(m1[l]) * 65'(x_r[0]);
      t2[l]     = 34'((p2_r[l] + 65'h4000_0000) >> 31);
      n_nxt[l]  = t2[l] + 34'(dv_i[l][8:1]);
      pr_nxt[l] = 68'(n_nxt[l]) * 68'(mr_i[l]);
      // reciprocal quotient is exact or one short; one compare fixes it
      q0[l]     = pr_r[l][67:34];
      rem[l]    = n_r[l] - 34'(43'(q0[l]) * 43'(dv_i[l]));
      tq[l]     = q0[l] + {33'd0, (rem[l] >= 34'(dv_i[l]))};
      acc_nxt[l] = sub_i ? (acc_r[2][l] - 36'(tq[l])) : (acc_r[2][l] + 36'(tq[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vld_o <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
      vld_o <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r       <= {x_r[1:0], x_i};
      acc_r     <= {acc_r[1:0], acc_i};
      side_r[0] <= side_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      pr_r      <= pr_nxt;
      n_r       <= n_nxt;
      x_o       <= x_r[2];
      for (int l = 0; l < 2; l++) begin
        t_o[l] <= tq[l][31:0];
      end
      acc_o     <= acc_nxt;
      side_o    <= side_r[2];
    end
  end

endmodule
